FILE: rtl/core/tbgr_pkg.sv
// ----------------------------------------------------------------------------
// tbgr_pkg
// Shared types, codes and the per-button tracking step of the two-button
// gesture recognizer.
// ----------------------------------------------------------------------------
package tbgr_pkg;

    localparam int TIME_W          = 32;
    localparam int EV_W            = 3;
    localparam int ACT_W           = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int QUEUE_DEPTH_DEF = 8;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_WIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DTAP_WIN   = 2'd2;

    localparam logic [TIME_W-1:0] LONG_PRESS_RST = 32'd800;
    localparam logic [TIME_W-1:0] CHORD_WIN_RST  = 32'd80;
    localparam logic [TIME_W-1:0] DTAP_WIN_RST   = 32'd300;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EV_W-1:0] EV_SHORT_OFS = 3'd1;
    localparam logic [EV_W-1:0] EV_LONG_OFS  = 3'd2;
    localparam logic [EV_W-1:0] EV_DOUBLE_OFS = 3'd3;
    localparam logic [EV_W-1:0] EV_BASE_FIRST  = 3'd0;
    localparam logic [EV_W-1:0] EV_BASE_SECOND = 3'd3;
    localparam logic [EV_W-1:0] EV_CHORD     = 3'd7;

    typedef struct packed {
        logic              down;
        logic              pend_short;
        logic              pend_second;
        logic              long_rep;
        logic              alone;
        logic [TIME_W-1:0] down_time;
        logic [TIME_W-1:0] rel_time;
    } t_track;

    // new tracking state plus up to two events, in queue order
    typedef struct packed {
        t_track          trk;
        logic            va;
        logic [EV_W-1:0] ea;
        logic            vb;
        logic [EV_W-1:0] eb;
    } t_track_upd;

    function automatic t_track_upd track_step(
        input t_track            t,
        input logic              pressed,
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] lim,
        input logic [TIME_W-1:0] win,
        input logic [EV_W-1:0]   base
    );
        t_track_upd        r;
        logic [TIME_W-1:0] d_rel;
        logic [TIME_W-1:0] d_down;
        logic              long_due;
        logic              short_due;
        logic              rel_now;
        d_rel  = now - t.rel_time;
        d_down = now - t.down_time;
        r.trk  = t;
        r.va   = 1'b0;
        r.ea   = EV_NONE;
        r.vb   = 1'b0;
        r.eb   = EV_NONE;
        rel_now = 1'b0;
        if (pressed) begin
            if (t.pend_short && (d_rel >= win)) begin
                r.va = 1'b1;
                r.ea = base + EV_SHORT_OFS;
                r.trk.pend_short = 1'b0;
            end
            if (!t.down) begin
                if (r.trk.pend_short) begin
                    r.trk.pend_short  = 1'b0;
                    r.trk.pend_second = 1'b1;
                end
                r.trk.down_time = now;
                r.trk.long_rep  = 1'b0;
                r.trk.alone     = 1'b1;
            end
            // fresh press has zero hold time
            long_due = t.down ? (d_down >= lim) : (lim == '0);
            if (r.trk.alone && !r.trk.long_rep && long_due) begin
                r.trk.long_rep    = 1'b1;
                r.trk.pend_short  = 1'b0;
                r.trk.pend_second = 1'b0;
                r.vb = 1'b1;
                r.eb = base + EV_LONG_OFS;
            end
        end else begin
            if (t.down && t.alone && !t.long_rep && (d_down < lim)) begin
                r.trk.alone = 1'b0;
                if (t.pend_second) begin
                    r.trk.pend_second = 1'b0;
                    r.va = 1'b1;
                    r.ea = base + EV_DOUBLE_OFS;
                end else begin
                    r.trk.pend_short = 1'b1;
                    r.trk.rel_time   = now;
                    rel_now          = 1'b1;
                end
            end
            short_due = rel_now ? (win == '0) : (d_rel >= win);
            if (r.trk.pend_short && short_due) begin
                r.trk.pend_short = 1'b0;
                r.vb = 1'b1;
                r.eb = base + EV_SHORT_OFS;
            end
        end
        r.trk.down = pressed;
        return r;
    endfunction

endpackage

FILE: rtl/core/tbgr_in_if.sv
// ----------------------------------------------------------------------------
// tbgr_in_if
// Input channel: action and timestamped button levels, valid/ready.
// ----------------------------------------------------------------------------
interface tbgr_in_if;
    logic                               valid;
    logic                               ready;
    logic [tbgr_pkg::ACT_W-1:0]         action;
    logic                               first_pressed;
    logic                               second_pressed;
    logic [tbgr_pkg::TIME_W-1:0]        now_ms;

    modport source (
        output valid, action, first_pressed, second_pressed, now_ms,
        input  ready
    );
    modport sink (
        input  valid, action, first_pressed, second_pressed, now_ms,
        output ready
    );
endinterface

FILE: rtl/core/tbgr_out_if.sv
// ----------------------------------------------------------------------------
// tbgr_out_if
// Result channel: popped event and queue status, valid/ready.
// ----------------------------------------------------------------------------
interface tbgr_out_if;
    logic                        valid;
    logic                        ready;
    logic [tbgr_pkg::EV_W-1:0]   event_res;
    logic                        queue_not_empty;

    modport source (
        output valid, event_res, queue_not_empty,
        input  ready
    );
    modport sink (
        input  valid, event_res, queue_not_empty,
        output ready
    );
endinterface

FILE: rtl/core/two_button_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// two_button_gesture_recognizer
// Short/long/double tap per button plus a two-button chord, with events
// buffered in a ring queue held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one action per transfer: a button sample with a timestamp,
//   a pop of one queued event, or a clear of all gesture and queue state.
//   o_out returns exactly one result per input transfer, in order: the popped
//   event (0 when none) and whether events remain queued.
//   Each result is registered in the stage-1 slot and then in the output slot,
//   and can transfer once it sits in the output slot.
//   Throughput is one item per cycle while i_in.ready is high. A sample that
//   queues k events (k up to 4) writes them one per cycle through the single
//   RAM write port, so the input is held off until the rest are written.
//   The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the hold
//   and window thresholds; write it only while the block is idle.
//   Reset clears the tracking state and queue pointers and reloads the default
//   thresholds. The event RAM is not cleared and needs no sweep: only entries
//   between head and tail are ever read.
//   Two result slots sit between the sides; when both are full because the
//   receiver stalls, i_in.ready drops until a result is taken.
// ----------------------------------------------------------------------------
module two_button_gesture_recognizer #(
    parameter int QUEUE_DEPTH = tbgr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tbgr_in_if.sink                          i_in,
    tbgr_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [tbgr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tbgr_pkg::TIME_W-1:0]      i_cfg_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TW = tbgr_pkg::TIME_W;
    localparam int EW = tbgr_pkg::EV_W;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // configuration
    logic [TW-1:0] r_long_lim, r_chord_win, r_dtap_win;

    // gesture state
    tbgr_pkg::t_track r_trk [2];
    tbgr_pkg::t_track n_trk [2];
    logic             r_chord_active, n_chord_active;
    logic             r_chord_rep, n_chord_rep;
    logic [TW-1:0]    r_chord_start, n_chord_start;

    // queue
    logic [EW-1:0] q_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_head, n_head, r_tail, n_tail;
    logic [EW-1:0] r_rd_data;

    // events still to be written after a multi-event sample
    logic [EW-1:0] r_evq [3];
    logic [EW-1:0] n_evq [3];
    logic [1:0]    r_evn, n_evn;

    // result pipeline
    logic          r_s1_valid, r_s1_mem, r_s1_ne;
    logic          r_out_valid, r_out_ne;
    logic [EW-1:0] r_out_ev;

    logic s2_free, s1_adv, s1_free, acc;
    logic acc_sample, acc_pop, acc_clear, pop_hit;
    logic w_en;
    logic [EW-1:0] w_ev;

    tbgr_pkg::t_track     trk_in [2];
    tbgr_pkg::t_track_upd upd [2];
    logic [TW-1:0]        d_chord;
    logic                 chord_due;
    logic [3:0]           ev_v;
    logic [EW-1:0]        ev_e [4];
    logic [EW-1:0]        ev_list [4];
    logic [2:0]           ev_cnt;

    assign s2_free  = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign i_in.ready = (r_evn == 2'd0) && s1_free;
    assign acc      = i_in.valid && i_in.ready;

    assign acc_sample = acc && (i_in.action == tbgr_pkg::ACT_SAMPLE);
    assign acc_pop    = acc && (i_in.action == tbgr_pkg::ACT_POP);
    assign acc_clear  = acc && (i_in.action == tbgr_pkg::ACT_CLEAR);
    assign pop_hit    = acc_pop && (r_head != r_tail);

    // ---------------- gesture evaluation ----------------
    assign d_chord = i_in.now_ms - r_chord_start;

    always_comb begin
        n_chord_active = r_chord_active;
        n_chord_rep    = r_chord_rep;
        n_chord_start  = r_chord_start;
        trk_in[0]      = r_trk[0];
        trk_in[1]      = r_trk[1];
        chord_due      = 1'b0;
        ev_v           = 4'b0000;
        ev_e[0]        = tbgr_pkg::EV_NONE;
        ev_e[1]        = tbgr_pkg::EV_NONE;
        ev_e[2]        = tbgr_pkg::EV_NONE;
        ev_e[3]        = tbgr_pkg::EV_NONE;
        if (!i_in.first_pressed || !i_in.second_pressed) begin
            if (r_chord_active) begin
                // chord ended: tracking restarts from scratch
                n_chord_active = 1'b0;
                n_chord_rep    = 1'b0;
                n_chord_start  = '0;
                trk_in[0]      = '0;
                trk_in[1]      = '0;
            end
        end
        upd[0] = tbgr_pkg::track_step(trk_in[0], i_in.first_pressed, i_in.now_ms,
                                      r_long_lim, r_dtap_win, tbgr_pkg::EV_BASE_FIRST);
        upd[1] = tbgr_pkg::track_step(trk_in[1], i_in.second_pressed, i_in.now_ms,
                                      r_long_lim, r_dtap_win, tbgr_pkg::EV_BASE_SECOND);
        n_trk[0] = upd[0].trk;
        n_trk[1] = upd[1].trk;
        if (i_in.first_pressed && i_in.second_pressed) begin
            n_trk[0] = r_trk[0];
            n_trk[1] = r_trk[1];
            if (!r_chord_active) begin
                n_chord_active = 1'b1;
                n_chord_start  = i_in.now_ms;
                n_trk[0]       = '0;
                n_trk[1]       = '0;
            end
            chord_due = r_chord_active ? (d_chord >= r_chord_win) : (r_chord_win == '0);
            if (!r_chord_rep && chord_due) begin
                n_chord_rep = 1'b1;
                ev_v[0]     = 1'b1;
                ev_e[0]     = tbgr_pkg::EV_CHORD;
            end
        end else begin
            ev_v    = {upd[1].vb, upd[1].va, upd[0].vb, upd[0].va};
            ev_e[0] = upd[0].ea;
            ev_e[1] = upd[0].eb;
            ev_e[2] = upd[1].ea;
            ev_e[3] = upd[1].eb;
        end
    end

    // pack valid events into queue order
    always_comb begin
        ev_cnt = 3'd0;
        for (int i = 0; i < 4; i++) begin
            ev_list[i] = tbgr_pkg::EV_NONE;
        end
        for (int i = 0; i < 4; i++) begin
            if (ev_v[i]) begin
                ev_list[ev_cnt[1:0]] = ev_e[i];
                ev_cnt = ev_cnt + 3'd1;
            end
        end
    end

    // ---------------- queue control ----------------
    assign w_en = (acc_sample && (ev_cnt != 3'd0)) || (r_evn != 2'd0);
    assign w_ev = (r_evn != 2'd0) ? r_evq[0] : ev_list[0];

    always_comb begin
        n_evn  = r_evn;
        n_evq  = r_evq;
        if (r_evn != 2'd0) begin
            n_evn    = r_evn - 2'd1;
            n_evq[0] = r_evq[1];
            n_evq[1] = r_evq[2];
            n_evq[2] = tbgr_pkg::EV_NONE;
        end else if (acc_sample && (ev_cnt != 3'd0)) begin
            n_evn    = 2'(ev_cnt - 3'd1);
            n_evq[0] = ev_list[1];
            n_evq[1] = ev_list[2];
            n_evq[2] = ev_list[3];
        end
    end

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (w_en) begin
            n_tail = ptr_inc(r_tail);
            // full: drop the oldest entry
            if (ptr_inc(r_tail) == r_head) begin
                n_head = ptr_inc(r_head);
            end
        end else if (pop_hit) begin
            n_head = ptr_inc(r_head);
        end else if (acc_clear) begin
            n_head = '0;
            n_tail = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            q_mem[r_tail] <= w_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_hit) begin
            r_rd_data <= q_mem[r_head];
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_lim  <= tbgr_pkg::LONG_PRESS_RST;
            r_chord_win <= tbgr_pkg::CHORD_WIN_RST;
            r_dtap_win  <= tbgr_pkg::DTAP_WIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbgr_pkg::CFG_LONG_PRESS: r_long_lim  <= i_cfg_data;
                tbgr_pkg::CFG_CHORD_WIN:  r_chord_win <= i_cfg_data;
                tbgr_pkg::CFG_DTAP_WIN:   r_dtap_win  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || acc_clear) begin
            r_trk[0]       <= '0;
            r_trk[1]       <= '0;
            r_chord_active <= 1'b0;
            r_chord_rep    <= 1'b0;
            r_chord_start  <= '0;
        end else if (acc_sample) begin
            r_trk[0]       <= n_trk[0];
            r_trk[1]       <= n_trk[1];
            r_chord_active <= n_chord_active;
            r_chord_rep    <= n_chord_rep;
            r_chord_start  <= n_chord_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_evn  <= 2'd0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_evn  <= n_evn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_evq <= n_evq;
    end

    // ---------------- result pipeline ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_mem <= pop_hit;
            r_s1_ne  <= (n_head != n_tail);
        end
        if (s1_adv) begin
            r_out_ev <= r_s1_mem ? r_rd_data : tbgr_pkg::EV_NONE;
            r_out_ne <= r_s1_ne;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.event_res       = r_out_ev;
    assign o_out.queue_not_empty = r_out_ne;

    // ---------------- assertions ----------------
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> (r_head != r_tail))
        else $error("queue empty right after an event write");

    a_pop_data_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_mem) |-> (r_rd_data != tbgr_pkg::EV_NONE))
        else $error("pop returned an empty event code");

    a_chord_clears_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chord_active |-> (!r_trk[0].down && !r_trk[1].down))
        else $error("button tracking active during chord");

    a_drain_follows_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_evn != 2'd0) |-> $past(w_en))
        else $error("pending event writes without a preceding write");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-button gesture recognizer. It runs directed
// gesture sequences and then randomized ones under several threshold settings.
// A behavioral predictor tracks both buttons, the chord and the event ring, and
// every result transfer is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;
    import tbgr_pkg::*;

    localparam int QDEPTH = QUEUE_DEPTH_DEF;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              first_pressed;
        logic              second_pressed;
        logic [TIME_W-1:0] now_ms;
    } gesture_item_t;

    typedef struct packed {
        logic [EV_W-1:0] event_res;
        logic            queue_not_empty;
    } gesture_result_t;

    typedef struct packed {
        bit              down;
        bit              pend_tap;
        bit              pend_retap;
        bit              long_done;
        bit              solo;
        bit [TIME_W-1:0] press_ms;
        bit [TIME_W-1:0] lift_ms;
    } button_track_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [TIME_W-1:0]    cfg_data;

    tbgr_in_if  in_ch();
    tbgr_out_if out_ch();

    two_button_gesture_recognizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor state
    bit [TIME_W-1:0] hold_lim;
    bit [TIME_W-1:0] chord_win;
    bit [TIME_W-1:0] dtap_win;
    button_track_t   btn [2];
    bit              chord_on;
    bit              chord_sent;
    bit [TIME_W-1:0] chord_t0;
    bit [EV_W-1:0]   gesture_ring [QDEPTH];
    int unsigned     ring_rd;
    int unsigned     ring_wr;

    gesture_item_t   stim_q[$];
    gesture_result_t predicted_results[$];

    logic            in_fire;
    bit              steady_run;
    bit              long_hold_done;
    int              hold_left;
    int              err_cnt;
    int              results_seen;
    int              gestures_popped;
    int              samples_sent;
    int              pops_sent;
    int              clears_sent;
    int              queued_items;
    bit [TIME_W-1:0] cur_ms;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void clear_tracks();
        btn[0] = '0;
        btn[1] = '0;
    endfunction

    function automatic void clear_gestures();
        clear_tracks();
        chord_on   = 1'b0;
        chord_sent = 1'b0;
        chord_t0   = '0;
        ring_rd    = 0;
        ring_wr    = 0;
    endfunction

    // ring drops its oldest entry when full
    function automatic void ring_push(bit [EV_W-1:0] ev);
        int unsigned nxt;
        nxt = (ring_wr + 1) % QDEPTH;
        if (nxt == ring_rd)
            ring_rd = (ring_rd + 1) % QDEPTH;
        gesture_ring[ring_wr] = ev;
        ring_wr = nxt;
    endfunction

    function automatic void advance_button(int b, bit pressed, bit [TIME_W-1:0] now,
                                           bit [EV_W-1:0] base);
        button_track_t t;
        bit            was_down;
        t = btn[b];
        was_down = t.down;
        if (pressed) begin
            if (t.pend_tap && (now - t.lift_ms) >= dtap_win) begin
                ring_push(base + EV_SHORT_OFS);
                t.pend_tap = 1'b0;
            end
            if (!was_down) begin
                if (t.pend_tap) begin
                    t.pend_tap   = 1'b0;
                    t.pend_retap = 1'b1;
                end
                t.press_ms  = now;
                t.long_done = 1'b0;
                t.solo      = 1'b1;
            end
            if (t.solo && !t.long_done && (now - t.press_ms) >= hold_lim) begin
                t.long_done  = 1'b1;
                t.pend_tap   = 1'b0;
                t.pend_retap = 1'b0;
                ring_push(base + EV_LONG_OFS);
            end
        end else begin
            if (was_down && t.solo && !t.long_done && (now - t.press_ms) < hold_lim) begin
                t.solo = 1'b0;
                if (t.pend_retap) begin
                    t.pend_retap = 1'b0;
                    ring_push(base + EV_DOUBLE_OFS);
                end else begin
                    t.pend_tap = 1'b1;
                    t.lift_ms  = now;
                end
            end
            if (t.pend_tap && (now - t.lift_ms) >= dtap_win) begin
                ring_push(base + EV_SHORT_OFS);
                t.pend_tap = 1'b0;
            end
        end
        t.down = pressed;
        btn[b] = t;
    endfunction

    function automatic gesture_result_t recognize(gesture_item_t it);
        gesture_result_t r;
        r.event_res = EV_NONE;
        case (it.action)
            ACT_SAMPLE: begin
                if (it.first_pressed && it.second_pressed) begin
                    if (!chord_on) begin
                        chord_on = 1'b1;
                        chord_t0 = it.now_ms;
                        clear_tracks();
                    end
                    if (!chord_sent && (it.now_ms - chord_t0) >= chord_win) begin
                        chord_sent = 1'b1;
                        ring_push(EV_CHORD);
                    end
                end else begin
                    if (chord_on) begin
                        chord_on   = 1'b0;
                        chord_sent = 1'b0;
                        chord_t0   = '0;
                        clear_tracks();
                    end
                    advance_button(0, it.first_pressed, it.now_ms, EV_BASE_FIRST);
                    advance_button(1, it.second_pressed, it.now_ms, EV_BASE_SECOND);
                end
            end
            ACT_POP: begin
                if (ring_rd != ring_wr) begin
                    r.event_res = gesture_ring[ring_rd];
                    ring_rd = (ring_rd + 1) % QDEPTH;
                end
            end
            ACT_CLEAR: clear_gestures();
            default: ;
        endcase
        r.queue_not_empty = (ring_rd != ring_wr);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input driver and transfer capture
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (stim_q.size() > 0 && (steady_run || $urandom_range(0, 99) >= 26)) begin
                in_ch.valid          <= 1'b1;
                in_ch.action         <= stim_q[0].action;
                in_ch.first_pressed  <= stim_q[0].first_pressed;
                in_ch.second_pressed <= stim_q[0].second_pressed;
                in_ch.now_ms         <= stim_q[0].now_ms;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        in_fire <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            void'(stim_q.pop_front());
            predicted_results.push_back(recognize({in_ch.action, in_ch.first_pressed,
                                                   in_ch.second_pressed, in_ch.now_ms}));
            case (in_ch.action)
                ACT_SAMPLE: samples_sent++;
                ACT_POP:    pops_sent++;
                ACT_CLEAR:  clears_sent++;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result side: ready with random stalls and one long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 180) begin
            long_hold_done = 1'b1;
            hold_left = 60;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady_run || $urandom_range(0, 99) >= 26;
        end
    end

    always @(posedge i_clk) begin
        gesture_result_t exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (predicted_results.size() == 0) begin
                err_cnt++;
                $display("%0t: result transfer with nothing expected: event_res %0d", $time,
                         out_ch.event_res);
            end else begin
                exp_r = predicted_results.pop_front();
                if (exp_r.event_res != EV_NONE)
                    gestures_popped++;
                if (out_ch.event_res !== exp_r.event_res) begin
                    err_cnt++;
                    $display("%0t: event_res mismatch: expected %0d, actual %0d", $time,
                             exp_r.event_res, out_ch.event_res);
                end
                if (out_ch.queue_not_empty !== exp_r.queue_not_empty) begin
                    err_cnt++;
                    $display("%0t: queue_not_empty mismatch: expected %0d, actual %0d", $time,
                             exp_r.queue_not_empty, out_ch.queue_not_empty);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(logic [ACT_W-1:0] act, bit f, bit s, bit [TIME_W-1:0] now);
        gesture_item_t it;
        it.action         = act;
        it.first_pressed  = f;
        it.second_pressed = s;
        it.now_ms         = now;
        stim_q.push_back(it);
        if (act != ACT_UNUSED)
            queued_items++;
    endtask

    task automatic set_levels(bit f, bit s, bit [TIME_W-1:0] dt);
        cur_ms = cur_ms + dt;
        add_item(ACT_SAMPLE, f, s, cur_ms);
    endtask

    task automatic press_one(int b, bit down, bit [TIME_W-1:0] dt);
        set_levels(b == 0 && down, b == 1 && down, dt);
    endtask

    function automatic bit [TIME_W-1:0] rand_thr();
        case ($urandom_range(0, 2))
            0: return hold_lim;
            1: return chord_win;
            default: return dtap_win;
        endcase
    endfunction

    // gaps cluster around the threshold edges
    function automatic bit [TIME_W-1:0] pick_gap(bit [TIME_W-1:0] thr);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return thr - 1;
            2: return thr;
            3: return thr + 1;
            4, 5, 6: return $urandom_range(0, thr);
            7, 8: return thr + $urandom_range(1, thr);
            default: return $urandom;
        endcase
    endfunction

    task automatic gesture_seq();
        int b;
        b = $urandom_range(0, 1);
        case ($urandom_range(0, 4))
            0: begin  // tap
                press_one(b, 1'b1, pick_gap(rand_thr()));
                press_one(b, 1'b0, pick_gap(hold_lim));
                if ($urandom_range(0, 1))
                    press_one(b, 1'b0, pick_gap(dtap_win));
            end
            1: begin  // hold
                press_one(b, 1'b1, pick_gap(rand_thr()));
                repeat ($urandom_range(1, 3)) press_one(b, 1'b1, pick_gap(hold_lim));
                press_one(b, 1'b0, pick_gap(hold_lim));
            end
            2: begin  // double
                press_one(b, 1'b1, pick_gap(rand_thr()));
                press_one(b, 1'b0, pick_gap(hold_lim));
                press_one(b, 1'b1, pick_gap(dtap_win));
                press_one(b, 1'b0, pick_gap(hold_lim));
                press_one(b, 1'b0, pick_gap(dtap_win));
            end
            3: begin  // chord
                press_one(b, 1'b1, pick_gap(rand_thr()));
                set_levels(1'b1, 1'b1, pick_gap(hold_lim));
                repeat ($urandom_range(1, 3)) set_levels(1'b1, 1'b1, pick_gap(chord_win));
                press_one(b, 1'b1, pick_gap(rand_thr()));
                set_levels(1'b0, 1'b0, pick_gap(rand_thr()));
            end
            default: begin
                repeat ($urandom_range(2, 5))
                    set_levels($urandom_range(0, 1), $urandom_range(0, 1), pick_gap(rand_thr()));
            end
        endcase
        repeat ($urandom_range(0, 4)) add_item(ACT_POP, 1'b0, 1'b0, $urandom);
    endtask

    task automatic random_mix(int n);
        int target;
        int r;
        target = queued_items + n;
        while (queued_items < target) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                gesture_seq();
            else if (r < 85)
                add_item(ACT_POP, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
            else if (r < 95)
                add_item(ACT_SAMPLE, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
            else if (r < 98)
                add_item(ACT_CLEAR, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
            else
                add_item(ACT_UNUSED, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
        end
    endtask

    task automatic drain();
        while (stim_q.size() > 0 || predicted_results.size() > 0 || in_ch.valid)
            @(posedge i_clk);
    endtask

    task automatic write_thresholds(bit [TIME_W-1:0] lim, bit [TIME_W-1:0] chord,
                                    bit [TIME_W-1:0] dtap);
        drain();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LONG_PRESS;
        cfg_data <= lim;
        hold_lim = lim;
        @(negedge i_clk);
        cfg_idx  <= CFG_CHORD_WIN;
        cfg_data <= chord;
        chord_win = chord;
        @(negedge i_clk);
        cfg_idx  <= CFG_DTAP_WIN;
        cfg_data <= dtap;
        dtap_win = dtap;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_LONG_PRESS;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.action         = ACT_SAMPLE;
        in_ch.first_pressed  = 1'b0;
        in_ch.second_pressed = 1'b0;
        in_ch.now_ms         = '0;
        out_ch.ready         = 1'b0;
        in_fire              = 1'b0;
        hold_lim             = LONG_PRESS_RST;
        chord_win            = CHORD_WIN_RST;
        dtap_win             = DTAP_WIN_RST;
        clear_gestures();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds, directed gestures first
        write_thresholds(LONG_PRESS_RST, CHORD_WIN_RST, DTAP_WIN_RST);
        add_item(ACT_POP, 1'b0, 1'b0, '0);
        add_item(ACT_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_item(ACT_SAMPLE, 1'b0, 1'b0, 32'd0);
        add_item(ACT_SAMPLE, 1'b1, 1'b0, 32'd1000);   // first: short tap
        add_item(ACT_SAMPLE, 1'b0, 1'b0, 32'd1100);
        add_item(ACT_SAMPLE, 1'b0, 1'b0, 32'd1500);
        add_item(ACT_SAMPLE, 1'b0, 1'b1, 32'd2000);   // second: long press
        add_item(ACT_SAMPLE, 1'b0, 1'b1, 32'd2900);
        add_item(ACT_SAMPLE, 1'b0, 1'b0, 32'd3000);
        add_item(ACT_SAMPLE, 1'b1, 1'b0, 32'd4000);   // first: double tap
        add_item(ACT_SAMPLE, 1'b0, 1'b0, 32'd4100);
        add_item(ACT_SAMPLE, 1'b1, 1'b0, 32'd4200);
        add_item(ACT_SAMPLE, 1'b0, 1'b0, 32'd4300);
        add_item(ACT_SAMPLE, 1'b1, 1'b0, 32'd5000);   // chord
        add_item(ACT_SAMPLE, 1'b1, 1'b1, 32'd5010);
        add_item(ACT_SAMPLE, 1'b1, 1'b1, 32'd5100);
        add_item(ACT_SAMPLE, 1'b0, 1'b0, 32'd5200);
        repeat (4) add_item(ACT_POP, 1'b0, 1'b0, '0);
        // tap across the counter wrap
        add_item(ACT_SAMPLE, 1'b0, 1'b1, 32'hFFFF_FF00);
        add_item(ACT_SAMPLE, 1'b0, 1'b0, 32'h0000_0050);
        add_item(ACT_SAMPLE, 1'b0, 1'b0, 32'hFFFF_FFFF);
        add_item(ACT_CLEAR, 1'b1, 1'b1, '0);
        add_item(ACT_POP, 1'b0, 1'b0, '0);
        cur_ms = 32'h0000_1000;
        steady_run = 1'b1;
        random_mix(80);
        drain();
        steady_run = 1'b0;

        // zero thresholds, ring overflow
        write_thresholds('0, '0, '0);
        repeat (10) begin
            set_levels(1'b1, 1'b1, 32'd1);
            set_levels(1'b0, 1'b0, 32'd1);
        end
        repeat (8) add_item(ACT_POP, 1'b0, 1'b0, '0);
        random_mix(80);

        write_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_mix(80);

        // small thresholds, with a full pause of the sender halfway
        write_thresholds($urandom_range(1, 40), $urandom_range(1, 20), $urandom_range(1, 40));
        random_mix(45);
        drain();
        random_mix(45);

        write_thresholds($urandom, $urandom, $urandom);
        random_mix(90);
        drain();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d samples, %0d pops, %0d clears over 5 threshold settings;",
                 samples_sent, pops_sent, clears_sent);
        $display("%0d results checked, %0d gestures read out of the ring.",
                 results_seen, gestures_popped);
        if (err_cnt == 0 && predicted_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", predicted_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule
